// ===== src/sorted_word_list_insert_defines.svh =====
// ---------------------------------------------------------------------------
// sorted word list assertion macros
// shared property forms for the sorted word list block
// ---------------------------------------------------------------------------
`ifndef SORTED_WORD_LIST_INSERT_DEFINES_SVH
`define SORTED_WORD_LIST_INSERT_DEFINES_SVH

// condition in the same cycle
`define SWLI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted word list check failed");

// condition in the following cycle
`define SWLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted word list check failed");

`endif

// ===== src/swli_pkg.sv =====
// ---------------------------------------------------------------------------
// sorted word list package
// shared types and constants of the sorted word list block
// ---------------------------------------------------------------------------
package swli_pkg;

  localparam int SLOT_BYTES = 16;
  localparam int LEN_W      = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [SLOT_BYTES-1:0][7:0] chars;
    logic [LEN_W-1:0]           len;
    logic                       too_long;
  } word_t;

endpackage

// ===== src/swli_front.sv =====
// ---------------------------------------------------------------------------
// sorted word list front end
// collects characters into the pending word and pushes finished words
// ---------------------------------------------------------------------------
module swli_front import swli_pkg::*; #(
  parameter int MAX_WORD_LEN = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       push,
  output word_t      push_word
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);

  logic [SLOT_BYTES-1:0][7:0] pend_chars;
  logic [LEN_W-1:0]           pend_len;
  word_t                      word_next;

  always_comb begin
    word_next.chars = pend_chars;
    if (pend_len < MAX_LEN) begin
      word_next.chars[pend_len[3:0]] = char_code;
      word_next.len = pend_len + 1'b1;
    end else begin
      word_next.len = MAX_LEN + 1'b1;
    end
    word_next.too_long = (word_next.len > MAX_LEN);
  end

  assign push      = accept & last_char;
  assign push_word = word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_len <= '0;
    end else if (accept) begin
      pend_len <= last_char ? '0 : word_next.len;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_chars <= word_next.chars;
    end
  end

endmodule

// ===== src/swli_queue.sv =====
// ---------------------------------------------------------------------------
// sorted word list word queue
// two-entry queue of finished words between front and back
// ---------------------------------------------------------------------------
module swli_queue import swli_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  input  logic  pop,
  output word_t head,
  output logic  empty,
  output logic  full
);

  word_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

// ===== src/swli_back.sv =====
// ---------------------------------------------------------------------------
// sorted word list back end
// checks length and room, searches the sorted list and inserts the word
// ---------------------------------------------------------------------------
`include "sorted_word_list_insert_defines.svh"

module swli_back import swli_pkg::*; #(
  parameter int MAX_WORDS      = 64,
  parameter int CAPACITY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  word_t      q_word,
  output logic       pop,
  output logic       done,
  output logic [1:0] status,
  output logic [5:0] insert_position,
  output logic [6:0] word_count,
  output logic [8:0] bytes_used
);

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int UW  = $clog2(CAPACITY_BYTES + 2);
  localparam int UW1 = UW + 1;
  localparam logic [CW-1:0]  MAXW = CW'(MAX_WORDS);
  localparam logic [UW1-1:0] CAP  = UW1'(CAPACITY_BYTES);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_RD_ORD  = 8'b0000_0100,
    S_RD_WORD = 8'b0000_1000,
    S_CMP     = 8'b0001_0000,
    S_SH_RD   = 8'b0010_0000,
    S_SH_WR   = 8'b0100_0000,
    S_WRITE   = 8'b1000_0000
  } state_t;

  state_t        state;
  word_t         cur;
  logic [CW-1:0] pos;
  logic [CW-1:0] r;
  logic [CW-1:0] r_dec;
  logic [CW-1:0] count;
  logic [UW-1:0] used;
  logic [AW-1:0] order_raddr;
  logic [AW-1:0] order_q;
  word_t         row_q;
  status_t       res_status;
  logic [CW-1:0] res_pos;
  logic          gt;

  logic [AW-1:0] order_mem [MAX_WORDS];
  word_t         word_mem  [MAX_WORDS];

  function automatic logic cmp_gt(input word_t a, input word_t b);
    logic [LEN_W-1:0] n;
    logic             res;
    n   = (a.len < b.len) ? a.len : b.len;
    res = (a.len > b.len);
    for (int i = SLOT_BYTES - 1; i >= 0; i--) begin
      if (LEN_W'(i) < n && a.chars[i] != b.chars[i]) begin
        res = (a.chars[i] > b.chars[i]);
      end
    end
    return res;
  endfunction

  assign gt          = cmp_gt(cur, row_q);
  assign r_dec       = r - 1'b1;
  assign order_raddr = (state == S_SH_RD) ? r_dec[AW-1:0] : pos[AW-1:0];
  assign pop         = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    order_q <= order_mem[order_raddr];
    row_q   <= word_mem[order_q];
    if (state == S_SH_WR) begin
      order_mem[r[AW-1:0]] <= order_q;
    end else if (state == S_WRITE) begin
      order_mem[pos[AW-1:0]] <= count[AW-1:0];
    end
    if (state == S_WRITE) begin
      word_mem[count[AW-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) state <= S_CHECK;
        end
        S_CHECK: begin
          pos <= '0;
          r   <= count;
          if (cur.too_long) begin
            res_status <= ST_TOO_LONG;
            res_pos    <= '0;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if ((UW1'(cur.len) + UW1'(used) > CAP) || count >= MAXW) begin
            res_status <= ST_NO_ROOM;
            res_pos    <= '0;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (count == '0) begin
            state <= S_SH_RD;
          end else begin
            state <= S_RD_ORD;
          end
        end
        S_RD_ORD:  state <= S_RD_WORD;
        S_RD_WORD: state <= S_CMP;
        S_CMP: begin
          r <= count;
          if (gt) begin
            pos   <= pos + 1'b1;
            state <= (pos + 1'b1 == count) ? S_SH_RD : S_RD_ORD;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          state <= (r == pos) ? S_WRITE : S_SH_WR;
        end
        S_SH_WR: begin
          r     <= r_dec;
          state <= S_SH_RD;
        end
        S_WRITE: begin
          used       <= UW'(UW1'(used) + UW1'(cur.len) + UW1'(count != '0));
          count      <= count + 1'b1;
          res_status <= ST_OK;
          res_pos    <= pos;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_word;
  end

  assign status          = res_status;
  assign insert_position = 6'(res_pos);
  assign word_count      = 7'(count);
  assign bytes_used      = 9'(used);

  `SWLI_ASSERT_NEXT(a_done_single, done, !done)
  `SWLI_ASSERT_IMPLY(a_count_max, 1'b1, count <= MAXW)
  `SWLI_ASSERT_IMPLY(a_used_max, 1'b1, UW1'(used) <= CAP + 1'b1)
  `SWLI_ASSERT_IMPLY(a_pos_in_list, done && res_status == ST_OK, res_pos < count)

endmodule

// ===== src/sorted_word_list_insert.sv =====
// ---------------------------------------------------------------------------
// sorted word list insert
// keeps words in ascending byte order and inserts each new word in place
// ---------------------------------------------------------------------------
// usage: a character beat is taken when start is high and busy is low; a
// beat with last_char high ends the word. busy rises while the two-entry
// word queue is full.
// per finished word, done pulses for one cycle with status, insert_position,
// word_count and bytes_used; the receiver cannot stall, so take it then.
// from the last character beat to done, with the back end idle, a rejected
// word is reported after the check; an insert does an order read, a row read
// and a compare for each stored word compared in the search, a read and a
// write for each rank shifted in the order memory, then writes the word.
// a queued word also waits for the back end to finish the word ahead of it.
// sustained rate: one character per cycle while the queue has room; word
// throughput is set by the search and shift loops of the back end.
// reset clears the list, the pending word and the queue; no clearing pass.
// ---------------------------------------------------------------------------
module sorted_word_list_insert import swli_pkg::*; #(
  parameter int MAX_WORDS      = 64,
  parameter int CAPACITY_BYTES = 256,
  parameter int MAX_WORD_LEN   = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       done,
  output logic [1:0] status,
  output logic [5:0] insert_position,
  output logic [6:0] word_count,
  output logic [8:0] bytes_used
);

  logic  accept;
  logic  push;
  word_t push_word;
  logic  pop;
  word_t head;
  logic  q_empty;
  logic  q_full;

  assign busy   = q_full;
  assign accept = start & ~q_full;

  swli_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push),
    .push_word (push_word)
  );

  swli_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  swli_back #(
    .MAX_WORDS      (MAX_WORDS),
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_word          (head),
    .pop             (pop),
    .done            (done),
    .status          (status),
    .insert_position (insert_position),
    .word_count      (word_count),
    .bytes_used      (bytes_used)
  );

endmodule
